@@ rtl/msptp_pkg.sv @@
`timescale 1ns / 1ps

package msptp_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int CAP_DEPTH   = 7;
	localparam int CAP_IDX_W   = $clog2(CAP_DEPTH);
	localparam int SEEN_W      = $clog2(MAX_PAYLOAD + 1);
	localparam int LEN_W       = 7;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_ARROW  = 8'h3E;

	localparam logic [7:0] CMD_STATUS   = 8'd101;
	localparam logic [7:0] CMD_ATTITUDE = 8'd108;
	localparam logic [7:0] CMD_ANALOG   = 8'd110;

	localparam logic [7:0] STATUS_MIN_LEN   = 8'd11;
	localparam logic [7:0] ATTITUDE_MIN_LEN = 8'd6;
	localparam logic [7:0] ANALOG_MIN_LEN   = 8'd7;

	typedef enum logic [2:0] {
		PH_DOLLAR,
		PH_M,
		PH_ARROW,
		PH_SIZE,
		PH_CMD,
		PH_PAYLOAD,
		PH_CHECK
	} msptp_phase_t;

	typedef struct packed {
		logic                        good;
		logic [7:0]                  cmd;
		logic [7:0]                  size;
		logic [CAP_DEPTH-1:0][7:0]   payload;
	} msptp_frame_t;

endpackage

@@ rtl/msptp_in_reg.sv @@
`timescale 1ns / 1ps

module msptp_in_reg import msptp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       out_free,
	output logic       fire,
	output logic [7:0] byte_s1
);

	logic valid_s1;

	assign fire     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

@@ rtl/msptp_frame_fsm.sv @@
`timescale 1ns / 1ps

module msptp_frame_fsm import msptp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  logic [7:0]   byte_s1,
	output msptp_frame_t frame
);

	msptp_phase_t             phase_q, phase_d;
	logic [7:0]               size_q, size_d;
	logic [7:0]               cmd_q, cmd_d;
	logic [SEEN_W-1:0]        seen_q, seen_d;
	logic [7:0]               check_q, check_d;
	logic [CAP_DEPTH-1:0][7:0] cap_q;
	logic                     cap_we;
	logic [SEEN_W-1:0]        seen_inc;

	assign seen_inc = seen_q + SEEN_W'(1);

	always_comb begin
		phase_d    = phase_q;
		size_d     = size_q;
		cmd_d      = cmd_q;
		seen_d     = seen_q;
		check_d    = check_q;
		cap_we     = 1'b0;
		frame.good = 1'b0;
		unique case (phase_q)
			PH_DOLLAR: begin
				if (byte_s1 == CH_DOLLAR) phase_d = PH_M;
			end
			PH_M: begin
				phase_d = (byte_s1 == CH_M) ? PH_ARROW : PH_DOLLAR;
			end
			PH_ARROW: begin
				phase_d = (byte_s1 == CH_ARROW) ? PH_SIZE : PH_DOLLAR;
			end
			PH_SIZE: begin
				size_d  = byte_s1;
				check_d = byte_s1;
				seen_d  = '0;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				cmd_d   = byte_s1;
				check_d = check_q ^ byte_s1;
				priority if (size_q == 8'd0) phase_d = PH_CHECK;
				else if (size_q > 8'(MAX_PAYLOAD)) phase_d = PH_DOLLAR;
				else phase_d = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				cap_we  = (seen_q < SEEN_W'(CAP_DEPTH));
				check_d = check_q ^ byte_s1;
				seen_d  = seen_inc;
				if (8'(seen_inc) >= size_q) phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				frame.good = (byte_s1 == check_q);
				phase_d    = PH_DOLLAR;
			end
			default: begin
				phase_d = PH_DOLLAR;
			end
		endcase
		frame.good    = frame.good && fire;
		frame.cmd     = cmd_q;
		frame.size    = size_q;
		frame.payload = cap_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DOLLAR;
			size_q  <= '0;
			cmd_q   <= '0;
			seen_q  <= '0;
			check_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			size_q  <= size_d;
			cmd_q   <= cmd_d;
			seen_q  <= seen_d;
			check_q <= check_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && cap_we) begin
			cap_q[seen_q[CAP_IDX_W-1:0]] <= byte_s1;
		end
	end

endmodule

@@ rtl/msptp_telemetry.sv @@
`timescale 1ns / 1ps

module msptp_telemetry import msptp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  msptp_frame_t      frame,
	output logic              out_free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        frame_code,
	output logic [LEN_W-1:0]  frame_length,
	output logic              armed,
	output logic signed [15:0] roll_tenths,
	output logic signed [15:0] pitch_tenths,
	output logic signed [15:0] heading_degrees,
	output logic [7:0]        battery_decivolts,
	output logic signed [15:0] current_centiamps
);

	// held telemetry lives in the result register; it only changes on a good frame
	logic        armed_d;
	logic [15:0] roll_d, pitch_d, yaw_d, cur_d;
	logic [7:0]  batt_d;

	assign out_free = !out_valid || out_ready;

	always_comb begin
		armed_d = armed;
		roll_d  = roll_tenths;
		pitch_d = pitch_tenths;
		yaw_d   = heading_degrees;
		batt_d  = battery_decivolts;
		cur_d   = current_centiamps;
		priority if (frame.cmd == CMD_STATUS && frame.size >= STATUS_MIN_LEN) begin
			armed_d = frame.payload[6][0];
		end else if (frame.cmd == CMD_ATTITUDE && frame.size >= ATTITUDE_MIN_LEN) begin
			roll_d  = {frame.payload[1], frame.payload[0]};
			pitch_d = {frame.payload[3], frame.payload[2]};
			yaw_d   = {frame.payload[5], frame.payload[4]};
		end else if (frame.cmd == CMD_ANALOG && frame.size >= ANALOG_MIN_LEN) begin
			batt_d = frame.payload[0];
			cur_d  = {frame.payload[6], frame.payload[5]};
		end else begin
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid         <= 1'b0;
			frame_code        <= '0;
			frame_length      <= '0;
			armed             <= 1'b0;
			roll_tenths       <= '0;
			pitch_tenths      <= '0;
			heading_degrees   <= '0;
			battery_decivolts <= '0;
			current_centiamps <= '0;
		end else if (frame.good) begin
			out_valid         <= 1'b1;
			frame_code        <= frame.cmd;
			frame_length      <= frame.size[LEN_W-1:0];
			armed             <= armed_d;
			roll_tenths       <= roll_d;
			pitch_tenths      <= pitch_d;
			heading_degrees   <= yaw_d;
			battery_decivolts <= batt_d;
			current_centiamps <= cur_d;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

@@ rtl/msp_v1_telemetry_parser.sv @@
// The checksum byte waits in byte_s1 until out_free; the frame result is then registered.
// Throughput: one byte item per cycle; the parser advances whenever the result
// register is empty or being taken, so a held result stalls input only behind it.
// Reset (arst_n low, asynchronous): parser waits for '$', all telemetry and
// frame fields read zero, no result is pending.
`timescale 1ns / 1ps

module msp_v1_telemetry_parser import msptp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         frame_code,
	output logic [LEN_W-1:0]   frame_length,
	output logic               armed,
	output logic signed [15:0] roll_tenths,
	output logic signed [15:0] pitch_tenths,
	output logic signed [15:0] heading_degrees,
	output logic [7:0]         battery_decivolts,
	output logic signed [15:0] current_centiamps
);

	logic         out_free;
	logic         fire;
	logic [7:0]   byte_s1;
	msptp_frame_t frame;

	msptp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.out_free (out_free),
		.fire     (fire),
		.byte_s1  (byte_s1)
	);

	msptp_frame_fsm u_frame_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.frame   (frame)
	);

	msptp_telemetry u_telemetry (
		.clk               (clk),
		.arst_n            (arst_n),
		.frame             (frame),
		.out_free          (out_free),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.frame_code        (frame_code),
		.frame_length      (frame_length),
		.armed             (armed),
		.roll_tenths       (roll_tenths),
		.pitch_tenths      (pitch_tenths),
		.heading_degrees   (heading_degrees),
		.battery_decivolts (battery_decivolts),
		.current_centiamps (current_centiamps)
	);

endmodule
